>>> hdl/ttt_pkg.sv
package ttt_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
  localparam int MAX_REPORT = 32;
  localparam int EMIT_W = $clog2(MAX_REPORT + 1);

  localparam int RANK_W = 5;
  localparam int ADDR_W = 32;
  localparam int CNT_W = 32;
  localparam int LEN_W = 16;
  localparam int VER_W = 4;
  localparam int PKT_W = 40;
  localparam int BYTE_W = 48;
  localparam int KEY_W = CNT_W + IDX_W;

  localparam logic [VER_W-1:0] IPV4_VER = VER_W'(4);
  localparam logic [LEN_W-1:0] MIN_LEN_RST = LEN_W'(34);

  typedef enum logic {
    REQ_PACKET = 1'b0,
    REQ_REPORT = 1'b1
  } req_t;

  typedef struct packed {
    logic accept_pkt;
    logic accept_rpt;
    logic scan_start;
    logic scan_run;
    logic tbl_write;
    logic emit;
    logic emit_empty;
  } ttt_cmd_t;

  typedef struct packed {
    logic track;
    logic occ_zero;
    logic scan_last;
    logic rpt_last;
  } ttt_sts_t;

endpackage

>>> hdl/ttt_ctrl.sv
module ttt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              req_type,
  input  ttt_pkg::ttt_sts_t sts,
  output ttt_pkg::ttt_cmd_t cmd,
  output logic              busy
);
  import ttt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PKT_SCAN,
    ST_PKT_WRITE,
    ST_RPT_SCAN,
    ST_RPT_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.scan_start = 1'b1;
          if (req_type == REQ_REPORT) begin
            cmd.accept_rpt = 1'b1;
            if (sts.occ_zero) begin
              cmd.emit_empty = 1'b1;
            end else begin
              state_nxt = ST_RPT_SCAN;
            end
          end else begin
            cmd.accept_pkt = 1'b1;
            if (sts.track) begin
              state_nxt = sts.occ_zero ? ST_PKT_WRITE : ST_PKT_SCAN;
            end
          end
        end
      end
      ST_PKT_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_PKT_WRITE;
        end
      end
      ST_PKT_WRITE: begin
        cmd.tbl_write = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_RPT_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_RPT_EMIT;
        end
      end
      ST_RPT_EMIT: begin
        cmd.emit       = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt      = sts.rpt_last ? ST_IDLE : ST_RPT_SCAN;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != ST_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

>>> hdl/ttt_dpath.sv
module ttt_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ttt_pkg::ttt_cmd_t             cmd,
  output ttt_pkg::ttt_sts_t             sts,
  input  logic [ttt_pkg::LEN_W-1:0]     in_pkt_len,
  input  logic [ttt_pkg::VER_W-1:0]     in_ip_version,
  input  logic [ttt_pkg::ADDR_W-1:0]    in_src_ip,
  input  logic                          cfg_valid,
  input  logic [ttt_pkg::LEN_W-1:0]     cfg_min_parse_len,
  output logic                          out_valid,
  output logic [ttt_pkg::ADDR_W-1:0]    out_talker_ip,
  output logic [ttt_pkg::CNT_W-1:0]     out_talker_count,
  output logic [ttt_pkg::RANK_W-1:0]    out_rank,
  output logic                          out_entry_valid,
  output logic                          out_last,
  output logic [ttt_pkg::PKT_W-1:0]     out_packets_total,
  output logic [ttt_pkg::BYTE_W-1:0]    out_bytes_total
);
  import ttt_pkg::*;

  logic [ADDR_W-1:0] mem_addr [TABLE_ENTRIES];
  logic [CNT_W-1:0]  mem_cnt  [TABLE_ENTRIES];

  logic [LEN_W-1:0]  min_len_r;
  logic [PKT_W-1:0]  pkt_r;
  logic [BYTE_W-1:0] byte_r;
  logic [BYTE_W:0]   byte_sum;
  logic [ADDR_W-1:0] src_r;
  logic [OCC_W-1:0]  occ_r;
  logic [OCC_W-1:0]  occ_nxt;

  logic [OCC_W-1:0]  scan_cnt_r;
  logic              issue;
  logic              pipe_vld_r;
  logic [IDX_W-1:0]  pipe_idx_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic [KEY_W-1:0]  cur_key;

  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [CNT_W-1:0]  hit_cnt_r;
  logic              min_vld_r;
  logic [IDX_W-1:0]  min_idx_r;
  logic [CNT_W-1:0]  min_cnt_r;
  logic              best_vld_r;
  logic [KEY_W-1:0]  best_key_r;
  logic [ADDR_W-1:0] best_addr_r;
  logic [KEY_W-1:0]  prev_key_r;
  logic              first_r;
  logic [RANK_W-1:0] rank_r;
  logic [EMIT_W-1:0] emit_num;
  logic              table_full;

  logic [IDX_W-1:0]  wr_idx;
  logic [CNT_W-1:0]  wr_cnt;

  logic              out_valid_r;
  logic [ADDR_W-1:0] out_ip_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic [RANK_W-1:0] out_rank_r;
  logic              out_ev_r;
  logic              out_last_r;
  logic [PKT_W-1:0]  out_pkt_r;
  logic [BYTE_W-1:0] out_byte_r;

  assign table_full = (32'(occ_r) >= 32'(TABLE_ENTRIES));
  assign byte_sum   = {1'b0, byte_r} + (BYTE_W + 1)'(in_pkt_len);
  assign issue      = cmd.scan_run && (scan_cnt_r < occ_r);
  assign cur_key    = {rd_cnt_r, ~pipe_idx_r};
  assign emit_num   = (32'(occ_r) > 32'(MAX_REPORT)) ? EMIT_W'(MAX_REPORT) : EMIT_W'(occ_r);
  assign occ_nxt    = occ_r + OCC_W'(1);

  assign sts.track     = (in_pkt_len >= min_len_r) && (in_ip_version == IPV4_VER);
  assign sts.occ_zero  = (occ_r == '0);
  assign sts.scan_last = pipe_vld_r && ((OCC_W'(pipe_idx_r) + OCC_W'(1)) == occ_r);
  assign sts.rpt_last  = ((32'(rank_r) + 32'd1) == 32'(emit_num));

  always_comb begin
    if (hit_r) begin
      wr_idx = hit_idx_r;
      wr_cnt = (hit_cnt_r == '1) ? hit_cnt_r : hit_cnt_r + CNT_W'(1);
    end else begin
      wr_idx = table_full ? min_idx_r : occ_r[IDX_W-1:0];
      wr_cnt = CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      pkt_r     <= '0;
      byte_r    <= '0;
      occ_r     <= '0;
    end else begin
      if (cfg_valid) begin
        min_len_r <= cfg_min_parse_len;
      end
      if (cmd.accept_pkt) begin
        pkt_r  <= (pkt_r == '1) ? pkt_r : pkt_r + PKT_W'(1);
        byte_r <= byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
      end
      if (cmd.tbl_write && !hit_r && !table_full) begin
        occ_r <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_pkt) begin
      src_r <= in_src_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_addr_r  <= mem_addr[scan_cnt_r[IDX_W-1:0]];
      rd_cnt_r   <= mem_cnt[scan_cnt_r[IDX_W-1:0]];
      pipe_idx_r <= scan_cnt_r[IDX_W-1:0];
    end
    if (cmd.tbl_write) begin
      mem_addr[wr_idx] <= src_r;
      mem_cnt[wr_idx]  <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      pipe_vld_r <= 1'b0;
      hit_r      <= 1'b0;
      min_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
      first_r    <= 1'b0;
      rank_r     <= '0;
    end else if (cmd.scan_start) begin
      scan_cnt_r <= '0;
      pipe_vld_r <= 1'b0;
      hit_r      <= 1'b0;
      min_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
      if (cmd.accept_rpt) begin
        first_r <= 1'b1;
        rank_r  <= '0;
      end else if (cmd.emit) begin
        first_r <= 1'b0;
        rank_r  <= rank_r + RANK_W'(1);
      end
    end else begin
      pipe_vld_r <= issue;
      if (issue) begin
        scan_cnt_r <= scan_cnt_r + OCC_W'(1);
      end
      if (pipe_vld_r) begin
        if (!hit_r && (rd_addr_r == src_r)) begin
          hit_r <= 1'b1;
        end
        if (!min_vld_r || (rd_cnt_r < min_cnt_r)) begin
          min_vld_r <= 1'b1;
        end
        if ((first_r || (cur_key < prev_key_r)) && (!best_vld_r || (cur_key > best_key_r))) begin
          best_vld_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_vld_r && !cmd.scan_start) begin
      if (!hit_r && (rd_addr_r == src_r)) begin
        hit_idx_r <= pipe_idx_r;
        hit_cnt_r <= rd_cnt_r;
      end
      if (!min_vld_r || (rd_cnt_r < min_cnt_r)) begin
        min_idx_r <= pipe_idx_r;
        min_cnt_r <= rd_cnt_r;
      end
      if ((first_r || (cur_key < prev_key_r)) && (!best_vld_r || (cur_key > best_key_r))) begin
        best_key_r  <= cur_key;
        best_addr_r <= rd_addr_r;
      end
    end
    if (cmd.emit) begin
      prev_key_r <= best_key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || cmd.emit_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ip_r   <= best_addr_r;
      out_cnt_r  <= best_key_r[KEY_W-1 -: CNT_W];
      out_rank_r <= rank_r;
      out_ev_r   <= 1'b1;
      out_last_r <= sts.rpt_last;
      out_pkt_r  <= pkt_r;
      out_byte_r <= byte_r;
    end else if (cmd.emit_empty) begin
      out_ip_r   <= '0;
      out_cnt_r  <= '0;
      out_rank_r <= '0;
      out_ev_r   <= 1'b0;
      out_last_r <= 1'b1;
      out_pkt_r  <= pkt_r;
      out_byte_r <= byte_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_talker_ip     = out_ip_r;
  assign out_talker_count  = out_cnt_r;
  assign out_rank          = out_rank_r;
  assign out_entry_valid   = out_ev_r;
  assign out_last          = out_last_r;
  assign out_packets_total = out_pkt_r;
  assign out_bytes_total   = out_byte_r;

endmodule

>>> hdl/top_talker_table_core.sv
// Channel   Handshake              Payload
// input     start & !busy          in_req_type, in_pkt_len, in_ip_version, in_src_ip
// result    out_valid (strobe)     out_talker_ip, out_talker_count, out_rank,
//                                  out_entry_valid, out_last, out_packets_total,
//                                  out_bytes_total
// config    cfg_valid & cfg_ready  cfg_min_parse_len
//
// A packet that is not tracked needs no scan and leaves busy low. A tracked packet scans the N
// occupied slots, one entry per cycle, and then writes its slot; on an empty table it goes
// straight to the write, since there is nothing to scan.
// A report on an empty table gives a single empty result without a scan. Any other report
// gives E = min(N, 32) results, and each rank rescans the table before its result is emitted.
// Reset is synchronous and active low; the table needs no clearing pass after reset.
// Each result is shown for one cycle and the receiver cannot stall it.
module top_talker_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [ttt_pkg::LEN_W-1:0]     in_pkt_len,
  input  logic [ttt_pkg::VER_W-1:0]     in_ip_version,
  input  logic [ttt_pkg::ADDR_W-1:0]    in_src_ip,
  output logic                          out_valid,
  output logic [ttt_pkg::ADDR_W-1:0]    out_talker_ip,
  output logic [ttt_pkg::CNT_W-1:0]     out_talker_count,
  output logic [ttt_pkg::RANK_W-1:0]    out_rank,
  output logic                          out_entry_valid,
  output logic                          out_last,
  output logic [ttt_pkg::PKT_W-1:0]     out_packets_total,
  output logic [ttt_pkg::BYTE_W-1:0]    out_bytes_total,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ttt_pkg::LEN_W-1:0]     cfg_min_parse_len
);
  import ttt_pkg::*;

  ttt_cmd_t cmd;
  ttt_sts_t sts;
  logic     ctl_start;

  assign cfg_ready = 1'b1;
  assign ctl_start = start && !busy;

  ttt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl_start),
    .req_type (in_req_type),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  ttt_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_pkt_len        (in_pkt_len),
    .in_ip_version     (in_ip_version),
    .in_src_ip         (in_src_ip),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_min_parse_len (cfg_min_parse_len),
    .out_valid         (out_valid),
    .out_talker_ip     (out_talker_ip),
    .out_talker_count  (out_talker_count),
    .out_rank          (out_rank),
    .out_entry_valid   (out_entry_valid),
    .out_last          (out_last),
    .out_packets_total (out_packets_total),
    .out_bytes_total   (out_bytes_total)
  );

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |-> out_last)
    else $error("Empty report result is not marked last.");

  a_rank_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rank != '0) |-> out_entry_valid)
    else $error("Ranked result carries no entry.");

  a_report_progress: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_start && (in_req_type == REQ_REPORT) |=> busy || out_valid)
    else $error("Accepted report neither started a scan nor gave a result.");

  a_write_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tbl_write |-> !busy || !cmd.scan_run)
    else $error("Table write overlaps a scan.");

endmodule
